>>> hw/rtl/cab_pkg.sv
// shared constants and types for the capacitated assignment search block
package cab_pkg;

  localparam int IDX_W      = 4;
  localparam int COST_W     = 16;
  localparam int OUT_W      = 20;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_W      = 5;

  localparam int MAX_TASKS_DEF    = 16;
  localparam int MAX_MACHINES_DEF = 16;
  localparam int COST_BITS_DEF    = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NUM_TASKS    = 2'd0,
    REG_NUM_MACHINES = 2'd1,
    REG_CAPACITY     = 2'd2
  } cfg_reg_t;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_STEP = 7'b0000010,
    S_ADD  = 7'b0000100,
    S_BND  = 7'b0001000,
    S_POP  = 7'b0010000,
    S_SUB  = 7'b0100000,
    S_DONE = 7'b1000000
  } search_state_t;

endpackage

>>> hw/rtl/cab_in_if.sv
// cost table entry channel
interface cab_in_if;
  logic                       valid;
  logic                       ready;
  logic [cab_pkg::IDX_W-1:0]  machine_index;
  logic [cab_pkg::IDX_W-1:0]  task_index;
  logic [cab_pkg::COST_W-1:0] cost;
  logic                       last_entry;
  modport source (output valid, machine_index, task_index, cost, last_entry, input ready);
  modport sink   (input valid, machine_index, task_index, cost, last_entry, output ready);
endinterface

>>> hw/rtl/cab_out_if.sv
// search result channel
interface cab_out_if;
  logic                      valid;
  logic                      ready;
  logic [cab_pkg::OUT_W-1:0] min_total_cost;
  logic                      feasible;
  modport source (output valid, min_total_cost, feasible, input ready);
  modport sink   (input valid, min_total_cost, feasible, output ready);
endinterface

>>> hw/rtl/cab_cfg_if.sv
// configuration register write channel
interface cab_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [cab_pkg::CFG_IDX_W-1:0] index;
  logic [cab_pkg::CFG_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> hw/rtl/cab_ram.sv
// generic single write, single read ram with registered read data
module cab_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/cab_search.sv
// depth-first branch and bound sequencer with choice stack ram and machine loads
module cab_search #(
  parameter int MAX_TASKS    = cab_pkg::MAX_TASKS_DEF,
  parameter int MAX_MACHINES = cab_pkg::MAX_MACHINES_DEF,
  parameter int COST_BITS    = cab_pkg::COST_BITS_DEF,
  parameter int TW           = $clog2(MAX_TASKS + 1),
  parameter int MW           = $clog2(MAX_MACHINES + 1),
  parameter int AW           = $clog2(MAX_TASKS * MAX_MACHINES),
  parameter int SW           = COST_BITS + $clog2(MAX_TASKS) + 1
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [TW-1:0]            n,
  input  logic [MW-1:0]            m,
  input  logic [cab_pkg::CFG_W-1:0] cap,
  input  logic [COST_BITS-1:0]     smallest,
  output logic [AW-1:0]            tbl_raddr,
  input  logic [COST_BITS-1:0]     tbl_rdata,
  output logic                     busy,
  output logic                     done,
  input  logic                     done_ack,
  output logic [SW-1:0]            best,
  output logic                     found
);

  localparam int KW  = $clog2(MAX_TASKS);
  localparam int MIW = $clog2(MAX_MACHINES);

  cab_pkg::search_state_t state_r, state_nxt;

  logic [KW-1:0]  k_r, k_nxt;
  logic [MW-1:0]  v_r, v_nxt;
  logic [MIW-1:0] cv_r, cv_nxt;
  logic [SW-1:0]  part_r, part_nxt;
  logic [SW-1:0]  best_r, best_nxt;
  logic           found_r, found_nxt;
  logic [SW-1:0]  sum_r, sum_nxt;
  logic [SW-1:0]  prod_r, prod_nxt;
  logic [TW-1:0]  load_r [MAX_MACHINES];

  logic           stk_we;
  logic [MW-1:0]  stk_wdata;
  logic [KW-1:0]  stk_raddr;
  logic [MW-1:0]  stk_rdata;

  logic [MIW-1:0] lidx;
  logic [TW-1:0]  lval;
  logic           load_inc, load_dec, load_clr;
  logic [SW-1:0]  sum_now;
  logic [TW-1:0]  rem;
  logic [MW-1:0]  pop_mach;

  cab_ram #(.WIDTH(MW), .DEPTH(MAX_TASKS)) u_stack (
    .clk   (clk),
    .we    (stk_we),
    .waddr (k_r),
    .wdata (stk_wdata),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  assign pop_mach = stk_rdata - MW'(1);
  assign lidx = (state_r == cab_pkg::S_POP) ? pop_mach[MIW-1:0] :
                (state_r == cab_pkg::S_BND) ? cv_r : v_r[MIW-1:0];
  assign lval = load_r[lidx];
  assign tbl_raddr = AW'(32'(lidx) * MAX_TASKS + 32'(k_r));
  assign stk_wdata = v_r + MW'(1);
  assign stk_raddr = k_r - KW'(1);
  assign sum_now = part_r + SW'(tbl_rdata);
  assign rem = n - TW'(1) - TW'(k_r);

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    v_nxt     = v_r;
    cv_nxt    = cv_r;
    part_nxt  = part_r;
    best_nxt  = best_r;
    found_nxt = found_r;
    sum_nxt   = sum_r;
    prod_nxt  = prod_r;
    stk_we    = 1'b0;
    load_inc  = 1'b0;
    load_dec  = 1'b0;
    load_clr  = 1'b0;
    unique case (state_r)
      cab_pkg::S_IDLE: begin
        if (start) begin
          load_clr  = 1'b1;
          k_nxt     = '0;
          v_nxt     = '0;
          part_nxt  = '0;
          found_nxt = 1'b0;
          best_nxt  = '1;
          if (n == '0) begin
            best_nxt  = '0;
            found_nxt = 1'b1;
            state_nxt = cab_pkg::S_DONE;
          end else begin
            state_nxt = cab_pkg::S_STEP;
          end
        end
      end
      cab_pkg::S_STEP: begin
        if (v_r >= m) begin
          if (k_r == '0) begin
            state_nxt = cab_pkg::S_DONE;
          end else begin
            k_nxt     = k_r - KW'(1);
            state_nxt = cab_pkg::S_POP;
          end
        end else begin
          stk_we = 1'b1;
          v_nxt  = v_r + MW'(1);
          cv_nxt = v_r[MIW-1:0];
          // machine full: try the next one
          if (32'(lval) < 32'(cap)) begin
            state_nxt = cab_pkg::S_ADD;
          end
        end
      end
      cab_pkg::S_ADD: begin
        if (TW'(k_r) + TW'(1) == n) begin
          if (sum_now < best_r) begin
            best_nxt = sum_now;
          end
          found_nxt = 1'b1;
          state_nxt = cab_pkg::S_STEP;
        end else begin
          sum_nxt   = sum_now;
          prod_nxt  = SW'(rem * smallest);
          state_nxt = cab_pkg::S_BND;
        end
      end
      cab_pkg::S_BND: begin
        // descend only if the optimistic completion can still win
        if (sum_r + prod_r < best_r) begin
          part_nxt = sum_r;
          load_inc = 1'b1;
          k_nxt    = k_r + KW'(1);
          v_nxt    = '0;
        end
        state_nxt = cab_pkg::S_STEP;
      end
      cab_pkg::S_POP: begin
        v_nxt     = stk_rdata;
        load_dec  = 1'b1;
        state_nxt = cab_pkg::S_SUB;
      end
      cab_pkg::S_SUB: begin
        part_nxt  = part_r - SW'(tbl_rdata);
        state_nxt = cab_pkg::S_STEP;
      end
      cab_pkg::S_DONE: begin
        if (done_ack) begin
          state_nxt = cab_pkg::S_IDLE;
        end
      end
      default: state_nxt = cab_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cab_pkg::S_IDLE;
      found_r <= 1'b0;
      for (int i = 0; i < MAX_MACHINES; i++) begin
        load_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      found_r <= found_nxt;
      if (load_clr) begin
        for (int i = 0; i < MAX_MACHINES; i++) begin
          load_r[i] <= '0;
        end
      end else if (load_inc) begin
        load_r[lidx] <= lval + TW'(1);
      end else if (load_dec) begin
        load_r[lidx] <= lval - TW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    k_r    <= k_nxt;
    v_r    <= v_nxt;
    cv_r   <= cv_nxt;
    part_r <= part_nxt;
    best_r <= best_nxt;
    sum_r  <= sum_nxt;
    prod_r <= prod_nxt;
  end

  assign busy  = (state_r != cab_pkg::S_IDLE);
  assign done  = (state_r == cab_pkg::S_DONE);
  assign best  = best_r;
  assign found = found_r;

endmodule

>>> hw/rtl/capacitated_assignment_bnb.sv
// top level: table loading, configuration registers, search and result register
//
// Usage: configure num_tasks, num_machines and capacity on the cfg_ channel
// (index 0, 1, 2; other indexes are dropped), then stream cost entries on the
// in_ channel, one per cycle, each giving machine, task and cost. Entries
// load into a machine-by-task table ram and update the running smallest cost.
// The entry with last_entry set is stored and then starts the branch-and-bound
// search; in_ready stays low while it runs.
// The search walks the tree through a sequencer around the table ram and the
// choice stack ram: each machine tried passes through the step, add and bound
// states (step and add alone when it completes an assignment, step alone when
// it is already full), and each backtrack through the step, pop and sub states.
// One result (min_total_cost, feasible) is given per last entry and sits in
// an output register until out_ready; while it waits, plain entries are still
// accepted, and a later search holds its result until the register frees.
// Reset: configuration returns to 1/1/1, the smallest cost to all ones; the
// table contents are undefined until written and survive between searches.
module capacitated_assignment_bnb #(
  parameter int MAX_TASKS    = cab_pkg::MAX_TASKS_DEF,
  parameter int MAX_MACHINES = cab_pkg::MAX_MACHINES_DEF,
  parameter int COST_BITS    = cab_pkg::COST_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  cab_in_if.sink    in_ch,
  cab_out_if.source out_ch,
  cab_cfg_if.sink   cfg_ch
);

  localparam int TW = $clog2(MAX_TASKS + 1);
  localparam int MW = $clog2(MAX_MACHINES + 1);
  localparam int AW = $clog2(MAX_TASKS * MAX_MACHINES);
  localparam int SW = COST_BITS + $clog2(MAX_TASKS) + 1;

  logic [cab_pkg::CFG_W-1:0] n_cfg_r, m_cfg_r, cap_r;
  logic [COST_BITS-1:0]      smallest_r;
  logic                      out_valid_r;
  logic [cab_pkg::OUT_W-1:0] out_cost_r;
  logic                      out_feas_r;

  logic                 in_xfer;
  logic [COST_BITS-1:0] in_cost;
  logic                 tbl_we;
  logic [AW-1:0]        tbl_waddr, tbl_raddr;
  logic [COST_BITS-1:0] tbl_rdata;
  logic [TW-1:0]        n_eff;
  logic [MW-1:0]        m_eff;
  logic                 busy, done, done_ack, found;
  logic [SW-1:0]        best;
  logic [63:0]          best_w;

  assign in_ch.ready  = !busy;
  assign cfg_ch.ready = 1'b1;
  assign in_xfer      = in_ch.valid && in_ch.ready;
  assign in_cost      = COST_BITS'(in_ch.cost);

  assign tbl_we = in_xfer && (32'(in_ch.machine_index) < MAX_MACHINES)
                          && (32'(in_ch.task_index) < MAX_TASKS);
  assign tbl_waddr = AW'(32'(in_ch.machine_index) * MAX_TASKS + 32'(in_ch.task_index));

  assign n_eff = (32'(n_cfg_r) > MAX_TASKS) ? TW'(MAX_TASKS) : TW'(n_cfg_r);
  assign m_eff = (32'(m_cfg_r) > MAX_MACHINES) ? MW'(MAX_MACHINES) : MW'(m_cfg_r);

  cab_ram #(.WIDTH(COST_BITS), .DEPTH(MAX_TASKS * MAX_MACHINES)) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (in_cost),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  cab_search #(
    .MAX_TASKS    (MAX_TASKS),
    .MAX_MACHINES (MAX_MACHINES),
    .COST_BITS    (COST_BITS),
    .TW           (TW),
    .MW           (MW),
    .AW           (AW),
    .SW           (SW)
  ) u_search (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_xfer && in_ch.last_entry),
    .n         (n_eff),
    .m         (m_eff),
    .cap       (cap_r),
    .smallest  (smallest_r),
    .tbl_raddr (tbl_raddr),
    .tbl_rdata (tbl_rdata),
    .busy      (busy),
    .done      (done),
    .done_ack  (done_ack),
    .best      (best),
    .found     (found)
  );

  assign done_ack = done && (!out_valid_r || out_ch.ready);
  assign best_w   = 64'(best);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_cfg_r     <= cab_pkg::CFG_W'(1);
      m_cfg_r     <= cab_pkg::CFG_W'(1);
      cap_r       <= cab_pkg::CFG_W'(1);
      smallest_r  <= '1;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        unique case (cfg_ch.index)
          cab_pkg::REG_NUM_TASKS:    n_cfg_r <= cfg_ch.data;
          cab_pkg::REG_NUM_MACHINES: m_cfg_r <= cfg_ch.data;
          cab_pkg::REG_CAPACITY:     cap_r   <= cfg_ch.data;
          default: ;
        endcase
      end
      if (in_xfer && (in_cost < smallest_r)) begin
        smallest_r <= in_cost;
      end
      if (done_ack) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // register the result: zero when infeasible, else the total saturated to the result width
  always_ff @(posedge clk) begin
    if (done_ack) begin
      out_feas_r <= found;
      if (!found) begin
        out_cost_r <= '0;
      end else if (best_w > 64'((1 << cab_pkg::OUT_W) - 1)) begin
        out_cost_r <= '1;
      end else begin
        out_cost_r <= best_w[cab_pkg::OUT_W-1:0];
      end
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.min_total_cost = out_cost_r;
  assign out_ch.feasible       = out_feas_r;

endmodule
